FILE: rtl/lrupr_pkg.sv
package lrupr_pkg;

  localparam int unsigned FRAME_COUNT = 8;
  localparam int unsigned PAGE_BITS   = 16;

  localparam int unsigned PAGE_NUMBER_W = 16;
  localparam int unsigned FRAME_INDEX_W = 3;

  localparam int unsigned IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(FRAME_COUNT + 1);

  typedef logic [PAGE_BITS-1:0]     page_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [PAGE_NUMBER_W-1:0] page_field_t;
  typedef logic [FRAME_INDEX_W-1:0] frame_field_t;

endpackage

FILE: rtl/lrupr_ram.sv
module lrupr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/lru_page_replacement_core.sv
// lru page replacement core
// input channel: one page reference request per handshake (in_valid_i / in_ready_o,
// page_number_i). output channel: one result per request (out_valid_o / out_ready_i)
// with fault, frame_index, evicted_valid and evicted_page.
// resident pages and the recency order (least recent first) live in two small
// synchronous memories. a request first scans the filled frames for the page, one
// frame per cycle, then on a hit or an eviction a second pass over the recency
// order moves the used frame to the most recent end, one entry per cycle through
// the single read port.
// one request is in flight at a time; in_ready_o rises at the edge that loads the
// result, so a new request is taken only once the last result has been loaded.
// the output register holds a result until out_ready_i; while it is stalled the
// next request is still accepted and worked on, and it waits before its own
// result is loaded.
// reset empties the frame set (filled count zero) and clears the output register;
// the memories themselves are not cleared, since only filled entries are read.
module lru_page_replacement_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [lrupr_pkg::PAGE_NUMBER_W-1:0]    page_number_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   fault_o,
  output logic [lrupr_pkg::FRAME_INDEX_W-1:0]    frame_index_o,
  output logic                                   evicted_valid_o,
  output logic [lrupr_pkg::PAGE_NUMBER_W-1:0]    evicted_page_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ORDER,
    ST_FINAL,
    ST_EVICT,
    ST_FILL,
    ST_DONE
  } state_e;

  state_e             state_q;
  lrupr_pkg::page_t   page_q;
  lrupr_pkg::page_t   evpage_q;
  lrupr_pkg::idx_t    ptr_q;
  lrupr_pkg::idx_t    idx_q;
  lrupr_pkg::idx_t    frame_q;
  lrupr_pkg::cnt_t    filled_q;
  logic               vld_q;
  logic               moving_q;
  logic               evict_q;
  logic               fault_q;
  logic               out_valid_q;

  logic               pg_we;
  lrupr_pkg::idx_t    pg_waddr;
  lrupr_pkg::page_t   pg_wdata;
  logic               pg_re;
  lrupr_pkg::idx_t    pg_raddr;
  lrupr_pkg::page_t   pg_rdata;

  logic               ro_we;
  lrupr_pkg::idx_t    ro_waddr;
  lrupr_pkg::idx_t    ro_wdata;
  logic               ro_re;
  lrupr_pkg::idx_t    ro_raddr;
  lrupr_pkg::idx_t    ro_rdata;

  lrupr_pkg::idx_t    last_idx;
  lrupr_pkg::idx_t    fill_idx;
  logic               full;
  logic               ptr_last;
  logic               match_now;

  assign last_idx  = lrupr_pkg::idx_t'(filled_q - lrupr_pkg::cnt_t'(1));
  assign fill_idx  = lrupr_pkg::idx_t'(filled_q);
  assign full      = (filled_q == lrupr_pkg::cnt_t'(lrupr_pkg::FRAME_COUNT));
  assign ptr_last  = (ptr_q == lrupr_pkg::idx_t'(lrupr_pkg::FRAME_COUNT - 1));
  assign match_now = vld_q && !moving_q &&
                     (evict_q ? (idx_q == '0) : (ro_rdata == frame_q));

  lrupr_ram #(
    .WIDTH (lrupr_pkg::PAGE_BITS),
    .DEPTH (lrupr_pkg::FRAME_COUNT),
    .AW    (lrupr_pkg::IDX_W)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (pg_we),
    .waddr_i (pg_waddr),
    .wdata_i (pg_wdata),
    .re_i    (pg_re),
    .raddr_i (pg_raddr),
    .rdata_o (pg_rdata)
  );

  lrupr_ram #(
    .WIDTH (lrupr_pkg::IDX_W),
    .DEPTH (lrupr_pkg::FRAME_COUNT),
    .AW    (lrupr_pkg::IDX_W)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ro_we),
    .waddr_i (ro_waddr),
    .wdata_i (ro_wdata),
    .re_i    (ro_re),
    .raddr_i (ro_raddr),
    .rdata_o (ro_rdata)
  );

  always_comb begin
    pg_we    = 1'b0;
    pg_waddr = '0;
    pg_wdata = page_q;
    pg_re    = 1'b0;
    pg_raddr = ptr_q;
    ro_we    = 1'b0;
    ro_waddr = '0;
    ro_wdata = frame_q;
    ro_re    = 1'b0;
    ro_raddr = ptr_q;
    case (state_q)
      ST_SCAN: begin
        pg_re = 1'b1;
      end
      ST_ORDER: begin
        ro_re = 1'b1;
        if (vld_q && moving_q) begin
          ro_we    = 1'b1;
          ro_waddr = idx_q - lrupr_pkg::idx_t'(1);
          ro_wdata = ro_rdata;
        end
      end
      ST_FINAL: begin
        ro_we    = 1'b1;
        ro_waddr = last_idx;
        pg_re    = evict_q;
        pg_raddr = frame_q;
      end
      ST_EVICT: begin
        pg_we    = 1'b1;
        pg_waddr = frame_q;
      end
      ST_FILL: begin
        pg_we    = 1'b1;
        pg_waddr = fill_idx;
        ro_we    = 1'b1;
        ro_waddr = fill_idx;
        ro_wdata = fill_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      page_q          <= '0;
      evpage_q        <= '0;
      ptr_q           <= '0;
      idx_q           <= '0;
      frame_q         <= '0;
      filled_q        <= '0;
      vld_q           <= 1'b0;
      moving_q        <= 1'b0;
      evict_q         <= 1'b0;
      fault_q         <= 1'b0;
      out_valid_q     <= 1'b0;
      fault_o         <= 1'b0;
      frame_index_o   <= '0;
      evicted_valid_o <= 1'b0;
      evicted_page_o  <= '0;
    end else begin
      if (out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            page_q   <= lrupr_pkg::page_t'(page_number_i);
            ptr_q    <= '0;
            vld_q    <= 1'b0;
            moving_q <= 1'b0;
            evict_q  <= 1'b0;
            state_q  <= (filled_q == '0) ? ST_FILL : ST_SCAN;
          end
        end
        ST_SCAN: begin
          idx_q <= ptr_q;
          if (vld_q && (pg_rdata == page_q)) begin
            frame_q <= idx_q;
            fault_q <= 1'b0;
            ptr_q   <= '0;
            vld_q   <= 1'b0;
            state_q <= ST_ORDER;
          end else if (vld_q && (idx_q == last_idx)) begin
            fault_q <= 1'b1;
            ptr_q   <= '0;
            vld_q   <= 1'b0;
            if (full) begin
              evict_q <= 1'b1;
              state_q <= ST_ORDER;
            end else begin
              state_q <= ST_FILL;
            end
          end else begin
            vld_q <= 1'b1;
            if (!ptr_last) begin
              ptr_q <= ptr_q + lrupr_pkg::idx_t'(1);
            end
          end
        end
        ST_ORDER: begin
          vld_q <= 1'b1;
          idx_q <= ptr_q;
          if (!ptr_last) begin
            ptr_q <= ptr_q + lrupr_pkg::idx_t'(1);
          end
          if (match_now) begin
            moving_q <= 1'b1;
            if (evict_q) begin
              frame_q <= ro_rdata;
            end
          end
          if (vld_q && (idx_q == last_idx)) begin
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          state_q <= evict_q ? ST_EVICT : ST_DONE;
        end
        ST_EVICT: begin
          evpage_q <= pg_rdata;
          state_q  <= ST_DONE;
        end
        ST_FILL: begin
          frame_q  <= fill_idx;
          fault_q  <= 1'b1;
          evict_q  <= 1'b0;
          filled_q <= filled_q + lrupr_pkg::cnt_t'(1);
          state_q  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q     <= 1'b1;
            fault_o         <= fault_q;
            frame_index_o   <= lrupr_pkg::frame_field_t'(frame_q);
            evicted_valid_o <= evict_q;
            evicted_page_o  <= evict_q ? lrupr_pkg::page_field_t'(evpage_q) : '0;
            state_q         <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/lrupr_checker.sv
module lrupr_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic                                fault_o,
  input logic [lrupr_pkg::FRAME_INDEX_W-1:0] frame_index_o,
  input logic                                evicted_valid_o,
  input logic [lrupr_pkg::PAGE_NUMBER_W-1:0] evicted_page_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fault_o) &&
    $stable(frame_index_o) && $stable(evicted_valid_o) && $stable(evicted_page_o))
    else $error("stalled result changed");

  // one request in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted back to back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_valid_o |-> fault_o)
    else $error("eviction without fault");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> evicted_page_o == '0)
    else $error("evicted page not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(frame_index_o) < lrupr_pkg::FRAME_COUNT)
    else $error("frame index out of range");

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .fault_o         (fault_o),
  .frame_index_o   (frame_index_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_page_o  (evicted_page_o)
);
